/* rtl/core/ofsd_pkg.sv */
// ============================================================================
// ofsd_pkg: shared types and constants
// Record, queue entry, queue status and back-end state types used by the
// filtered descending sort unit.
// ============================================================================
package ofsd_pkg;

    localparam int ID_W          = 16;
    localparam int DAYS_W        = 16;
    localparam int BOOKS_W       = 4;
    localparam int DEF_MAX_ENTRIES = 64;

    localparam logic [DAYS_W-1:0] THRESHOLD_RESET = 16'd7;

    // Two-entry queue between the front and the back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QFILL_W = 2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DAYS_W-1:0] days;
        logic              keep;
        logic              last;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMPTY
    } t_back_state;

endpackage

/* rtl/core/overdue_filter_sort_desc_unit.sv */
// ============================================================================
// overdue_filter_sort_desc_unit: filtered descending sort of borrower records
// Keeps records with books on loan and overdue days above a threshold, and
// emits them in descending order of overdue days after the final record.
// ============================================================================
// Usage:
// A request is taken on a rising edge with start high and busy low. A record
// is kept when books_on_loan is non-zero and overdue_days is strictly greater
// than the threshold register, written through the cfg channel (always ready).
// It must be written only while the unit is idle; the unit does not enforce
// this. Its reset value is 7. Requests pass through a two-entry queue into a
// row of sorted cells that takes one record per cycle, so a load streams in at
// one request per cycle while the row is loading. When the request marked
// last_in leaves the queue, the row drains one result per cycle from the
// largest key down into the result register; a run with no kept records gives
// a single none_found result instead. While the row drains, the queue fills
// and busy rises after two further requests.
// Each result is shown for one cycle with o_result_valid; the receiver cannot
// stall it. Equal keys come out in arrival order; records beyond MAX_ENTRIES
// are dropped. Reset empties the row and the queue and restores the threshold.
// ============================================================================
module overdue_filter_sort_desc_unit
    import ofsd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DAYS_W-1:0]   i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [ID_W-1:0]     i_reader_id,
    input  logic [BOOKS_W-1:0]  i_books_on_loan,
    input  logic [DAYS_W-1:0]   i_overdue_days,
    input  logic                i_last_in,
    output logic                o_result_valid,
    output logic [ID_W-1:0]     o_out_reader_id,
    output logic [DAYS_W-1:0]   o_out_overdue_days,
    output logic                o_last_out,
    output logic                o_none_found
);

    t_queue_status q_status;
    t_qentry       push_entry;
    t_qentry       head_entry;
    logic          push;
    logic          pop;

    ofsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_reader_id     (i_reader_id),
        .i_books_on_loan (i_books_on_loan),
        .i_overdue_days  (i_overdue_days),
        .i_last_in       (i_last_in),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    ofsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    ofsd_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_status         (q_status),
        .i_entry            (head_entry),
        .o_pop              (pop),
        .o_result_valid     (o_result_valid),
        .o_out_reader_id    (o_out_reader_id),
        .o_out_overdue_days (o_out_overdue_days),
        .o_last_out         (o_last_out),
        .o_none_found       (o_none_found)
    );

`ifndef ASSERT_OFF
    // The sorter never takes from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // An empty-run result is always the end of the run and carries zeros.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_none_found) |->
            (o_last_out && o_out_reader_id == '0 && o_out_overdue_days == '0))
        else $error("none_found result malformed");

    // Within one run the keys never increase.
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid) && !$past(o_last_out)) |->
            (o_out_overdue_days <= $past(o_out_overdue_days)))
        else $error("results out of order");
`endif

endmodule

/* rtl/core/ofsd_front.sv */
// ============================================================================
// ofsd_front: request intake and filter
// Holds the threshold register, takes requests while the queue has room and
// marks each record as kept or dropped before it enters the queue.
// ============================================================================
module ofsd_front
    import ofsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DAYS_W-1:0]   i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [ID_W-1:0]     i_reader_id,
    input  logic [BOOKS_W-1:0]  i_books_on_loan,
    input  logic [DAYS_W-1:0]   i_overdue_days,
    input  logic                i_last_in,
    input  t_queue_status       i_q_status,
    output logic                o_push,
    output t_qentry             o_entry
);

    logic [DAYS_W-1:0] r_threshold;
    logic [DAYS_W-1:0] n_threshold;

    assign o_cfg_ready = 1'b1;
    assign busy        = i_q_status.full;
    assign o_push      = start && !i_q_status.full;

    always_comb begin
        n_threshold = r_threshold;
        if (i_cfg_valid && o_cfg_ready) begin
            n_threshold = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else begin
            r_threshold <= n_threshold;
        end
    end

    always_comb begin
        o_entry.id   = i_reader_id;
        o_entry.days = i_overdue_days;
        o_entry.keep = (i_books_on_loan != '0) && (i_overdue_days > r_threshold);
        o_entry.last = i_last_in;
    end

endmodule

/* rtl/core/ofsd_queue.sv */
// ============================================================================
// ofsd_queue: short request queue
// Two-entry first-in first-out queue that decouples intake from the sorter.
// ============================================================================
module ofsd_queue
    import ofsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_qentry       i_entry,
    input  logic          i_pop,
    output t_qentry       o_entry,
    output t_queue_status o_status
);

    t_qentry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QFILL_W-1:0]  r_fill;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QFILL_W-1:0]  n_fill;

    assign o_status.full  = (r_fill == QFILL_W'(QDEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/ofsd_back.sv */
// ============================================================================
// ofsd_back: insertion chain and drain
// A row of sorted cells takes one kept record per cycle; after the final
// record the row shifts out one result per cycle, or none_found if none kept.
// ============================================================================
module ofsd_back
    import ofsd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_status       i_q_status,
    input  t_qentry             i_entry,
    output logic                o_pop,
    output logic                o_result_valid,
    output logic [ID_W-1:0]     o_out_reader_id,
    output logic [DAYS_W-1:0]   o_out_overdue_days,
    output logic                o_last_out,
    output logic                o_none_found
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [ID_W-1:0]   r_id  [MAX_ENTRIES];
    logic [DAYS_W-1:0] r_key [MAX_ENTRIES];
    logic [ID_W-1:0]   n_id  [MAX_ENTRIES];
    logic [DAYS_W-1:0] n_key [MAX_ENTRIES];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_back_state       r_state;
    t_back_state       n_state;

    logic              r_res_valid;
    logic [ID_W-1:0]   r_res_id;
    logic [DAYS_W-1:0] r_res_days;
    logic              r_res_last;
    logic              r_res_none;

    logic [MAX_ENTRIES-1:0] ge;
    logic              insert;
    logic              shift;
    logic              emit_rec;
    logic              emit_none;

    // Output decode per state.
    always_comb begin
        o_pop     = 1'b0;
        shift     = 1'b0;
        emit_rec  = 1'b0;
        emit_none = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_pop = !i_q_status.empty;
            end
            ST_DRAIN: begin
                shift    = 1'b1;
                emit_rec = 1'b1;
            end
            ST_EMPTY: begin
                emit_none = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign insert = o_pop && i_entry.keep && (r_count < CNT_W'(MAX_ENTRIES));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (o_pop && i_entry.last) begin
                    if (r_count == '0 && !insert) begin
                        n_state = ST_EMPTY;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (r_count == CNT_W'(1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_EMPTY: begin
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // A new record goes after every stored record whose key is not smaller,
    // so equal keys stay in arrival order.
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ge[i] = (CNT_W'(i) < r_count) && (r_key[i] >= i_entry.days);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_id[i]  = r_id[i];
            n_key[i] = r_key[i];
            if (shift) begin
                if (i < MAX_ENTRIES - 1) begin
                    n_id[i]  = r_id[i + 1];
                    n_key[i] = r_key[i + 1];
                end
            end else if (insert && !ge[i]) begin
                if (i == 0) begin
                    n_id[i]  = i_entry.id;
                    n_key[i] = i_entry.days;
                end else if (ge[i - 1]) begin
                    n_id[i]  = i_entry.id;
                    n_key[i] = i_entry.days;
                end else begin
                    n_id[i]  = r_id[i - 1];
                    n_key[i] = r_key[i - 1];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (insert) begin
            n_count = r_count + 1'b1;
        end else if (shift) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= emit_rec || emit_none;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            r_id[i]  <= n_id[i];
            r_key[i] <= n_key[i];
        end
        r_res_id   <= emit_rec ? r_id[0]  : '0;
        r_res_days <= emit_rec ? r_key[0] : '0;
        r_res_last <= emit_none || (r_count == CNT_W'(1));
        r_res_none <= emit_none;
    end

    assign o_result_valid     = r_res_valid;
    assign o_out_reader_id    = r_res_id;
    assign o_out_overdue_days = r_res_days;
    assign o_last_out         = r_res_last;
    assign o_none_found       = r_res_none;

endmodule
